FILE: rtl/servo_packet_framer_checker_defines.svh
// Assertion macros used by the servo packet engine checker.
`ifndef SERVO_PACKET_FRAMER_CHECKER_DEFINES_SVH
`define SERVO_PACKET_FRAMER_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define SPFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define SPFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spfc_pkg.sv
// Types, codes and the CRC step function of the servo packet engine.
`default_nettype none

package spfc_pkg;

    // input opcodes
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_TX_PARAM = 2'd1;
    localparam logic [1:0] OP_RX_BYTE  = 2'd2;
    localparam logic [1:0] OP_RX_END   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // receive status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NONE       = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_CRC_BAD    = 3'd3;
    localparam logic [2:0] ST_DEV_ERROR  = 3'd4;

    // framing bytes
    localparam logic [7:0] HDR_SYNC = 8'hFF;
    localparam logic [7:0] HDR_MARK = 8'hFD;
    localparam logic [7:0] HDR_ZERO = 8'h00;
    localparam logic [7:0] LEN_EXTRA = 8'd3;

    // reply layout
    localparam int MIN_REPLY    = 11;
    localparam int ERR_BYTE_POS = 8;
    localparam int PAYLOAD_POS  = 9;

    localparam logic [15:0] CRC_POLY = 16'h8005;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX_HDR,
        S_TX_PARAM,
        S_TX_CRC_LO,
        S_TX_CRC_HI,
        S_RX_READ,
        S_RX_USE,
        S_RX_STATUS
    } t_state;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/servo_packet_framer_checker.sv
// Servo-bus packet engine: transmit framer and receive reply checker.
//
// Transmit: a start word sends FF FF FD 00, the device id, the length (count + 3, then 00)
// and the instruction; each parameter word is echoed; after the last parameter the CRC-16
// (poly 0x8005, init 0) goes out low byte first, o_last set on the high byte. Receive: byte
// words are written into an RX_DEPTH-entry buffer memory (extra ones dropped); an end word
// walks the buffer, sends payload bytes 9..n-3 when n >= 11, then one status word. One
// input word is worked at a time; results wait in the output register until taken. The
// buffer memory has a registered read port, so each buffered byte is read in one state
// (S_RX_READ) and used in the next (S_RX_USE).
`default_nettype none

module servo_packet_framer_checker #(
    parameter int MAX_PARAMS = 16,
    parameter int RX_DEPTH   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input words
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_instruction,
    input  wire logic [4:0] i_param_count,
    input  wire logic [7:0] i_data_byte,
    // result words
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status_code,
    output logic [7:0]      o_device_error,
    output logic            o_last,
    // device id register
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);

    localparam int AW    = $clog2(RX_DEPTH);
    localparam int CNT_W = $clog2(RX_DEPTH + 1);

    // control state
    spfc_pkg::t_state r_state, n_state;
    logic [2:0]       r_hdr_idx, n_hdr_idx;
    logic [4:0]       r_tx_left, n_tx_left;
    logic             r_tx_open, n_tx_open;
    logic [15:0]      r_tx_crc, n_tx_crc;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic             r_lo_ok, n_lo_ok;
    logic [7:0]       r_err, n_err;
    logic [2:0]       r_code, n_code;
    logic [7:0]       r_device_id;

    // latched input payload
    logic [7:0]       r_instr, n_instr;
    logic [7:0]       r_param, n_param;

    // output register
    logic             r_o_valid;
    logic [1:0]       r_o_kind;
    logic [7:0]       r_o_byte;
    logic [2:0]       r_o_code;
    logic [7:0]       r_o_derr;
    logic             r_o_last;

    // receive buffer memory
    logic [7:0]       r_rx_mem [RX_DEPTH];
    logic [7:0]       r_rd_data;
    logic             mem_we;

    logic             in_acc;
    logic             can_emit;
    logic             emit;
    logic [1:0]       e_kind;
    logic [7:0]       e_byte;
    logic [2:0]       e_code;
    logic [7:0]       e_derr;
    logic             e_last;
    logic [4:0]       cnt_sat;
    logic [7:0]       hdr_byte;
    logic [CNT_W-1:0] n_m2;
    logic [CNT_W-1:0] idx_ext;
    logic [15:0]      crc_step;

    assign o_in_ready = (r_state == spfc_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign can_emit   = !r_o_valid || i_out_ready;

    // parameter count saturation
    assign cnt_sat = ({3'b000, i_param_count} > 8'(MAX_PARAMS)) ? 5'(MAX_PARAMS)
                                                                  : i_param_count;

    assign n_m2     = r_rx_count - CNT_W'(2);
    assign idx_ext  = CNT_W'(r_idx);
    assign crc_step = spfc_pkg::crc_byte(r_rx_crc, r_rd_data);

    // header byte by position
    always_comb begin
        case (r_hdr_idx)
            3'd0:    hdr_byte = spfc_pkg::HDR_SYNC;
            3'd1:    hdr_byte = spfc_pkg::HDR_SYNC;
            3'd2:    hdr_byte = spfc_pkg::HDR_MARK;
            3'd3:    hdr_byte = spfc_pkg::HDR_ZERO;
            3'd4:    hdr_byte = r_device_id;
            3'd5:    hdr_byte = {3'b000, r_tx_left} + spfc_pkg::LEN_EXTRA;
            3'd6:    hdr_byte = spfc_pkg::HDR_ZERO;
            default: hdr_byte = r_instr;
        endcase
    end

    // sequencer: next state and emitted word
    always_comb begin
        n_state    = r_state;
        n_hdr_idx  = r_hdr_idx;
        n_tx_left  = r_tx_left;
        n_tx_open  = r_tx_open;
        n_tx_crc   = r_tx_crc;
        n_rx_count = r_rx_count;
        n_idx      = r_idx;
        n_rx_crc   = r_rx_crc;
        n_lo_ok    = r_lo_ok;
        n_err      = r_err;
        n_code     = r_code;
        n_instr    = r_instr;
        n_param    = r_param;
        mem_we     = 1'b0;
        emit       = 1'b0;
        e_kind     = spfc_pkg::KIND_TX;
        e_byte     = 8'h00;
        e_code     = spfc_pkg::ST_OK;
        e_derr     = 8'h00;
        e_last     = 1'b0;

        case (r_state)
            spfc_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        spfc_pkg::OP_START: begin
                            n_tx_crc  = 16'h0000;
                            n_hdr_idx = 3'd0;
                            n_instr   = i_instruction;
                            n_tx_left = cnt_sat;
                            n_tx_open = 1'b1;
                            n_state   = spfc_pkg::S_TX_HDR;
                        end
                        spfc_pkg::OP_TX_PARAM: begin
                            if (r_tx_open && (r_tx_left != 5'd0)) begin
                                n_param = i_data_byte;
                                n_state = spfc_pkg::S_TX_PARAM;
                            end
                        end
                        spfc_pkg::OP_RX_BYTE: begin
                            if (r_rx_count < CNT_W'(RX_DEPTH)) begin
                                mem_we     = 1'b1;
                                n_rx_count = r_rx_count + CNT_W'(1);
                            end
                        end
                        default: begin
                            n_err = 8'h00;
                            if (r_rx_count == CNT_W'(0)) begin
                                n_code  = spfc_pkg::ST_NONE;
                                n_state = spfc_pkg::S_RX_STATUS;
                            end else if (r_rx_count < CNT_W'(spfc_pkg::MIN_REPLY)) begin
                                n_code  = spfc_pkg::ST_INCOMPLETE;
                                n_state = spfc_pkg::S_RX_STATUS;
                            end else begin
                                n_idx    = '0;
                                n_rx_crc = 16'h0000;
                                n_lo_ok  = 1'b0;
                                n_state  = spfc_pkg::S_RX_READ;
                            end
                        end
                    endcase
                end
            end

            // header, one byte a cycle while the output is taken
            spfc_pkg::S_TX_HDR: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    e_byte    = hdr_byte;
                    n_tx_crc  = spfc_pkg::crc_byte(r_tx_crc, hdr_byte);
                    n_hdr_idx = r_hdr_idx + 3'd1;
                    if (r_hdr_idx == 3'd7) begin
                        n_state = (r_tx_left == 5'd0) ? spfc_pkg::S_TX_CRC_LO
                                                      : spfc_pkg::S_IDLE;
                    end
                end
            end

            spfc_pkg::S_TX_PARAM: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    e_byte    = r_param;
                    n_tx_crc  = spfc_pkg::crc_byte(r_tx_crc, r_param);
                    n_tx_left = r_tx_left - 5'd1;
                    n_state   = (r_tx_left == 5'd1) ? spfc_pkg::S_TX_CRC_LO
                                                    : spfc_pkg::S_IDLE;
                end
            end

            spfc_pkg::S_TX_CRC_LO: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_byte  = r_tx_crc[7:0];
                    n_state = spfc_pkg::S_TX_CRC_HI;
                end
            end

            // closing byte ends the packet
            spfc_pkg::S_TX_CRC_HI: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    e_byte    = r_tx_crc[15:8];
                    e_last    = 1'b1;
                    n_tx_crc  = 16'h0000;
                    n_tx_left = 5'd0;
                    n_tx_open = 1'b0;
                    n_state   = spfc_pkg::S_IDLE;
                end
            end

            // buffer read in flight
            spfc_pkg::S_RX_READ: begin
                n_state = spfc_pkg::S_RX_USE;
            end

            // use the byte just read
            spfc_pkg::S_RX_USE: begin
                if (idx_ext < n_m2) begin
                    if (r_idx >= AW'(spfc_pkg::PAYLOAD_POS)) begin
                        if (can_emit) begin
                            emit     = 1'b1;
                            e_kind   = spfc_pkg::KIND_PAYLOAD;
                            e_byte   = r_rd_data;
                            n_rx_crc = crc_step;
                            n_idx    = r_idx + AW'(1);
                            n_state  = spfc_pkg::S_RX_READ;
                        end
                    end else begin
                        if (r_idx == AW'(spfc_pkg::ERR_BYTE_POS)) begin
                            n_err = r_rd_data;
                        end
                        n_rx_crc = crc_step;
                        n_idx    = r_idx + AW'(1);
                        n_state  = spfc_pkg::S_RX_READ;
                    end
                end else if (idx_ext == n_m2) begin
                    n_lo_ok = (r_rd_data == r_rx_crc[7:0]);
                    n_idx   = r_idx + AW'(1);
                    n_state = spfc_pkg::S_RX_READ;
                end else begin
                    if (!(r_lo_ok && (r_rd_data == r_rx_crc[15:8]))) begin
                        n_code = spfc_pkg::ST_CRC_BAD;
                    end else if (r_err != 8'h00) begin
                        n_code = spfc_pkg::ST_DEV_ERROR;
                    end else begin
                        n_code = spfc_pkg::ST_OK;
                    end
                    n_state = spfc_pkg::S_RX_STATUS;
                end
            end

            // status word closes the reply and empties the buffer
            spfc_pkg::S_RX_STATUS: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_kind     = spfc_pkg::KIND_STATUS;
                    e_code     = r_code;
                    e_derr     = (r_code == spfc_pkg::ST_DEV_ERROR) ? r_err : 8'h00;
                    e_last     = 1'b1;
                    n_rx_count = '0;
                    n_state    = spfc_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = spfc_pkg::S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spfc_pkg::S_IDLE;
            r_tx_left   <= 5'd0;
            r_tx_open   <= 1'b0;
            r_tx_crc    <= 16'h0000;
            r_rx_count  <= '0;
            r_device_id <= 8'd1;
            r_o_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tx_left  <= n_tx_left;
            r_tx_open  <= n_tx_open;
            r_tx_crc   <= n_tx_crc;
            r_rx_count <= n_rx_count;
            if (i_cfg_we) begin
                r_device_id <= i_cfg_data;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_hdr_idx <= n_hdr_idx;
        r_idx     <= n_idx;
        r_rx_crc  <= n_rx_crc;
        r_lo_ok   <= n_lo_ok;
        r_err     <= n_err;
        r_code    <= n_code;
        r_instr   <= n_instr;
        r_param   <= n_param;
        if (emit) begin
            r_o_kind <= e_kind;
            r_o_byte <= e_byte;
            r_o_code <= e_code;
            r_o_derr <= e_derr;
            r_o_last <= e_last;
        end
    end

    // receive buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rx_mem[r_rx_count[AW-1:0]] <= i_data_byte;
        end
        r_rd_data <= r_rx_mem[r_idx];
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_kind     = r_o_kind;
    assign o_out_byte     = r_o_byte;
    assign o_status_code  = r_o_code;
    assign o_device_error = r_o_derr;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

FILE: rtl/spfc_checker.sv
// Port-level checks of the servo packet engine, bound to its top level.
`default_nettype none
`include "servo_packet_framer_checker_defines.svh"

module spfc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [1:0] i_opcode,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_out_kind,
    input wire logic [7:0] o_out_byte,
    input wire logic [2:0] o_status_code,
    input wire logic [7:0] o_device_error,
    input wire logic       o_last
);

    // a stalled result word holds
    `SPFC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_out_kind) && $stable(o_last), "stalled result word changed")

    // every status word closes its run
    `SPFC_ASSERT_NOW(a_status_last, o_out_valid && (o_out_kind == spfc_pkg::KIND_STATUS), o_last, "status word without last")

    // byte words carry no status
    `SPFC_ASSERT_NOW(a_byte_clean, o_out_valid && (o_out_kind != spfc_pkg::KIND_STATUS), (o_status_code == spfc_pkg::ST_OK) && (o_device_error == 8'h00), "byte word carries status fields")

    // start and end words always occupy the engine
    `SPFC_ASSERT_NEXT(a_busy_after, i_in_valid && o_in_ready && ((i_opcode == spfc_pkg::OP_START) || (i_opcode == spfc_pkg::OP_RX_END)), !o_in_ready, "engine ready right after start or end word")

endmodule

bind servo_packet_framer_checker spfc_checker u_spfc_checker (.*);

`default_nettype wire
